### rtl/itda_pkg.sv
// Shared types and constants for the integer to decimal ASCII converter.
`default_nettype none

package itda_pkg;

    // ASCII codes emitted by the block
    localparam logic [5:0] C_CHR_ZERO  = 6'd48;
    localparam logic [5:0] C_CHR_MINUS = 6'd45;

    localparam int C_RADIX      = 10;
    localparam int C_MAX_DIGITS = 10;

    // Magnitude and digit position widths
    localparam int C_MAG_W  = 32;
    localparam int C_POS_W  = 4;
    localparam int C_WIDE_W = C_MAG_W + 2;

    typedef logic [C_MAG_W-1:0]  t_mag;
    typedef logic [C_POS_W-1:0]  t_pos;
    typedef logic [C_WIDE_W-1:0] t_wide;

    // Multiples d * 10^k for k and d in 0..9, wide enough for 9 * 10^9
    typedef logic [C_MAX_DIGITS-1:0][C_RADIX-1:0][C_WIDE_W-1:0] t_pm_tab;

    function automatic t_pm_tab build_pm();
        t_pm_tab tab;
        longint unsigned p;
        tab = '0;
        p   = 1;
        for (int k = 0; k < C_MAX_DIGITS; k++) begin
            for (int d = 0; d < C_RADIX; d++) begin
                tab[k][d] = t_wide'(p * longint'(d));
            end
            p = p * longint'(C_RADIX);
        end
        return tab;
    endfunction

    localparam t_pm_tab C_PM = build_pm();

    // One classified number waiting for conversion
    typedef struct packed {
        logic neg;
        t_mag mag;
        t_pos kmax;
    } t_item;

endpackage

`default_nettype wire

### rtl/int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
// Input channel: i_valid / o_stall carry one signed 32-bit i_value per
// transfer. Output channel: o_valid / i_stall carry one ASCII character per
// transfer, o_character being '-' or '0'..'9', with o_last set on the final
// character of the number. A negative value starts with '-'; zero gives '0'.
// The front end forms the magnitude and digit count in the transfer cycle and
// writes a two-entry queue. The back end takes one number from the queue and
// emits one character per cycle through an output register while i_stall is
// low, so a number of n characters (1 to 11) leaves in n successive
// transfers, and back-to-back numbers stream without gaps. The digit generator
// compares the remainder against the nine multiples of the current power of
// ten each cycle.
// Reset (synchronous, active low) empties the queue and the output register.
// When the receiver stalls, the output character holds, the back end waits,
// and the queue absorbs up to two further numbers before o_stall rises.
`default_nettype none

module int_to_decimal_ascii
    import itda_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [5:0]              o_character,
    output logic                    o_last
);

    logic  push;
    logic  full;
    logic  q_valid;
    logic  pop;
    t_item f_item;
    t_item q_item;

    // Classify incoming values
    itda_front u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_push  (push),
        .o_item  (f_item),
        .i_full  (full)
    );

    // Decouple front and back
    itda_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    // Generate characters
    itda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

### rtl/itda_front.sv
// Front end: accepts a value, forms sign and magnitude, counts its digits.
`default_nettype none

module itda_front
    import itda_pkg::*;
(
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_value,
    output logic                    o_push,
    output t_item                   o_item,
    input  wire logic               i_full
);

    logic raw_neg;
    t_mag raw;
    t_mag mag;
    t_pos kmax;

    // Take the magnitude at 32 bits unsigned so the most negative value is exact
    assign raw     = t_mag'(i_value);
    assign raw_neg = raw[C_MAG_W-1];
    assign mag     = raw_neg ? t_mag'(t_mag'(0) - raw) : raw;

    // Count the powers of ten that the magnitude reaches
    always_comb begin
        kmax = '0;
        for (int k = 1; k < C_MAX_DIGITS; k++) begin
            kmax = kmax + t_pos'({2'b00, mag} >= C_PM[k][1]);
        end
    end

    // Hand the classified number to the queue
    assign o_stall     = i_full;
    assign o_push      = i_valid && !i_full;
    assign o_item.neg  = raw_neg;
    assign o_item.mag  = mag;
    assign o_item.kmax = kmax;

endmodule

`default_nettype wire

### rtl/itda_fifo.sv
// Two-entry queue between the front end and the digit generator.
`default_nettype none

module itda_fifo
    import itda_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    // Advance pointers and count on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Store payload without reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/itda_back.sv
// Back end: emits the sign and the decimal digits, most significant first.
`default_nettype none

module itda_back
    import itda_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_item      i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [5:0]      o_character,
    output logic            o_last
);

    logic       r_busy;
    logic       r_neg_pend;
    t_mag       r_rem;
    t_pos       r_k;
    logic       r_ovalid;
    logic [5:0] r_char;
    logic       r_last;

    logic       out_free;
    logic       emit;
    logic       finish;
    t_pos       digit;
    t_wide      sub;

    // Find the digit at the current position by comparing against its multiples
    always_comb begin
        digit = '0;
        for (int d = 1; d < C_RADIX; d++) begin
            digit = digit + t_pos'({2'b00, r_rem} >= C_PM[r_k][d]);
        end
        sub = C_PM[r_k][digit];
    end

    assign out_free = !r_ovalid || !i_stall;
    assign emit     = r_busy && out_free;
    assign finish   = emit && !r_neg_pend && (r_k == '0);
    assign o_pop    = i_valid && (!r_busy || finish);

    // Load a number, then step through sign and digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_neg_pend <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy     <= 1'b1;
                r_neg_pend <= i_item.neg;
                r_rem      <= i_item.mag;
                r_k        <= i_item.kmax;
            end else if (emit) begin
                if (r_neg_pend) begin
                    r_neg_pend <= 1'b0;
                end else begin
                    r_rem <= t_mag'({2'b00, r_rem} - sub);
                    r_k   <= r_k - t_pos'(1);
                    if (r_k == '0) begin
                        r_busy <= 1'b0;
                    end
                end
            end
            if (out_free) begin
                r_ovalid <= emit;
            end
        end
    end

    // Hold the output character while stalled
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_neg_pend) begin
                r_char <= C_CHR_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= C_CHR_ZERO + {2'b00, digit};
                r_last <= (r_k == '0);
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire

### rtl/itda_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none

module itda_checker
    import itda_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [5:0] o_character,
    input wire logic       o_last
);

    // Stalled output holds its character
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output changed while stalled");

    // Only sign and digit codes leave the block
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == C_CHR_MINUS) ||
                    ((o_character >= C_CHR_ZERO) && (o_character <= C_CHR_ZERO + 6'd9)))
        else $error("illegal character code");

    // A sign is never marked as the last character
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == C_CHR_MINUS) |-> !o_last)
        else $error("sign marked as last character");

    // Reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_character (o_character),
    .o_last      (o_last)
);

`default_nettype wire

### verif/int_to_decimal_ascii_chk.sv
// Checker for the integer to decimal ASCII converter: predicts and compares characters.
module int_to_decimal_ascii_chk
    import itda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [5:0]  i_character,
    input  logic        i_last,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_numbers,
    output int          o_negatives,
    output int          o_chars
);

    typedef struct packed {
        logic [5:0] chr;
        logic       last;
    } t_char;

    t_char pending_chars[$];
    t_char want;
    int    fail_cnt   = 0;
    int    num_cnt    = 0;
    int    neg_cnt    = 0;
    int    char_cnt   = 0;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] int_to_decimal_ascii_chk: %s", $time, msg);
        fail_cnt++;
    endtask

    // Queue the decimal text of one number, sign first, most significant digit first
    function automatic void decimal_text(input logic [31:0] value);
        logic       neg;
        t_mag       mag;
        logic [3:0] digs[C_MAX_DIGITS];
        int         nd;
        neg = value[31];
        mag = neg ? t_mag'(32'd0 - value) : t_mag'(value);
        nd  = 0;
        do begin
            digs[nd] = 4'(mag % C_RADIX);
            mag      = mag / C_RADIX;
            nd++;
        end while (mag != 0 && nd < C_MAX_DIGITS);
        if (neg) begin
            pending_chars.push_back('{chr: C_CHR_MINUS, last: 1'b0});
        end
        for (int i = nd - 1; i >= 0; i--) begin
            pending_chars.push_back('{chr: C_CHR_ZERO + 6'(digs[i]), last: (i == 0)});
        end
    endfunction

    // Predict on each input transfer, compare on each output transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                decimal_text(i_value);
                num_cnt++;
                if (i_value[31]) begin
                    neg_cnt++;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                char_cnt++;
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %0d last %0b",
                                              i_character, i_last));
                end else begin
                    want = pending_chars.pop_front();
                    if (i_character !== want.chr) begin
                        report_mismatch($sformatf("character %0d, expected %0d",
                                                  i_character, want.chr));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last flag %0b on character %0d, expected %0b",
                                                  i_last, want.chr, want.last));
                    end
                end
            end
        end
        o_pending    <= pending_chars.size();
        o_fail_count <= fail_cnt;
        o_numbers    <= num_cnt;
        o_negatives  <= neg_cnt;
        o_chars      <= char_cnt;
    end

endmodule

### verif/int_to_decimal_ascii_tb.sv
// Testbench top for the integer to decimal ASCII converter: stimulus, output stalls and verdict.
module int_to_decimal_ascii_tb;
    import itda_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int LIMIT_CYCLES   = 400_000;
    localparam int HOLD_CYCLES    = 100;
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_value = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [5:0]  o_character;
    logic        o_last;

    int pending_chars;
    int fail_count;
    int numbers_done;
    int negatives_done;
    int chars_done;

    // Phase controls shared by the sender and receiver processes
    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    bit rx_hold_req = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    int_to_decimal_ascii DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    int_to_decimal_ascii_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_value      (i_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_character  (o_character),
        .i_last       (o_last),
        .o_pending    (pending_chars),
        .o_fail_count (fail_count),
        .o_numbers    (numbers_done),
        .o_negatives  (negatives_done),
        .o_chars      (chars_done)
    );

    // Offer one number after a random gap and hold it until the transfer
    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
    endtask

    // Drop valid and wait until every queued character has come out
    task automatic drain_output();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars != 0);
    endtask

    // Draw a number, mostly with a random digit count and sign
    function automatic logic [31:0] draw_value();
        int unsigned     ndig;
        longint unsigned span;
        longint unsigned m;
        logic [31:0]     v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom();
        end else begin
            ndig = $urandom_range(1, 10);
            span = 1;
            repeat (ndig) span = span * 10;
            m = longint'($urandom()) % span;
            v = $urandom_range(0, 1) ? 32'(64'd0 - m) : 32'(m);
        end
        return v;
    endfunction

    // Receiver: random stall before each character, or one long hold when asked
    initial begin : rx_proc
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_en) begin
                gap = $urandom_range(0, 9);
                if (gap != 0) begin
                    i_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // End the run if it hangs
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("int_to_decimal_ascii_tb: FAIL");
        $finish;
    end

    // Stimulus phases and verdict
    initial begin : stim_proc
        logic [31:0] corner[$];
        corner = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1_000_000_000,
                   32'd999_999_999, -32'sd999_999_999, 32'd1_234_567_890,
                   -32'sd1_000_000_000, 32'd7, -32'sd5, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'd4_294_967, 32'd0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners with idling on both sides
        foreach (corner[i]) send_value(corner[i]);

        // Random numbers with idling
        repeat (150) send_value(draw_value());

        // Back-to-back stretch with no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (80) send_value(draw_value());

        // Long output hold-off while the sender keeps offering, so the input stalls
        rx_hold_req = 1'b1;
        repeat (12) send_value(draw_value());

        // Pause the sender until the output has caught up
        drain_output();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // Random numbers with idling and an occasional drain
        repeat (90) begin
            send_value(draw_value());
            if ($urandom_range(0, 29) == 0) begin
                drain_output();
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("int_to_decimal_ascii_tb: %0d numbers (%0d negative) gave %0d characters,",
                 numbers_done, negatives_done, chars_done);
        $display("int_to_decimal_ascii_tb: corners, random lengths, back-to-back, hold-off, drain");
        if (fail_count == 0 && pending_chars == 0) begin
            $display("int_to_decimal_ascii_tb: PASS");
        end else begin
            $display("int_to_decimal_ascii_tb: FAIL");
        end
        $finish;
    end

endmodule
